@@ sv/light_lux_from_channels_top_macros.svh @@
// Assertion helpers used by the top-level module.
`ifndef LIGHT_LUX_FROM_CHANNELS_TOP_MACROS_SVH
`define LIGHT_LUX_FROM_CHANNELS_TOP_MACROS_SVH

// same-cycle implication
`define LLFC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("llfc assertion failed");

// implication in the next cycle
`define LLFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("llfc assertion failed");

`endif

@@ sv/llfc_pkg.sv @@
`default_nettype none
package llfc_pkg;

  localparam int RAW_W      = 16;
  localparam int LUX_W      = 24;
  localparam int CHAN_SHIFT = 10;
  localparam int RATIO_BITS = 9;
  localparam int LUX_BITS   = 14;
  localparam int SEG_COUNT  = 7;
  localparam int FACTOR_W   = 19;
  localparam int COEF_W     = 10;
  localparam int KNEE_W     = 10;

  // raw * factor, then >> CHAN_SHIFT
  localparam int PROD_W   = RAW_W + FACTOR_W;
  localparam int SCALED_W = PROD_W - CHAN_SHIFT;
  // knee compare: c0 * (2k+1) against c1 << (RATIO_BITS+1)
  localparam int CMP_W    = SCALED_W + KNEE_W + 1;

  localparam logic [FACTOR_W-1:0] CHAN_FACTOR = FACTOR_W'(32'h7517 << 4);

  localparam logic [KNEE_W-1:0] KNEE [SEG_COUNT] = '{
    10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a
  };
  localparam logic [COEF_W-1:0] ICEPT [SEG_COUNT] = '{
    10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018
  };
  localparam logic [COEF_W-1:0] SLOPE [SEG_COUNT] = '{
    10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012
  };

  typedef struct packed {
    logic [SCALED_W-1:0] c0;
    logic [SCALED_W-1:0] c1;
  } scaled_t;

  typedef struct packed {
    scaled_t              ch;
    logic [SEG_COUNT-1:0] hit;
  } knee_t;

  typedef struct packed {
    logic [PROD_W-1:0] pos;
    logic [PROD_W-1:0] neg;
  } terms_t;

endpackage
`default_nettype wire

@@ sv/llfc_in_if.sv @@
`default_nettype none
interface llfc_in_if;
  import llfc_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] broadband_count;
  logic [RAW_W-1:0] infrared_count;

  modport source (output valid, output broadband_count, output infrared_count,
                  input ready);
  modport sink (input valid, input broadband_count, input infrared_count,
                output ready);
endinterface
`default_nettype wire

@@ sv/llfc_out_if.sv @@
`default_nettype none
interface llfc_out_if;
  import llfc_pkg::*;

  logic             valid;
  logic             ready;
  logic [LUX_W-1:0] lux;

  modport source (output valid, output lux, input ready);
  modport sink (input valid, input lux, output ready);
endinterface
`default_nettype wire

@@ sv/llfc_scale.sv @@
`default_nettype none
module llfc_scale (
  input  logic              clk,
  input  logic              rst,
  llfc_in_if.sink           sample,
  output logic              ch_valid,
  input  logic              ch_ready,
  output llfc_pkg::scaled_t ch
);
  import llfc_pkg::*;

  logic [PROD_W-1:0] p0;
  logic [PROD_W-1:0] p1;
  scaled_t           ch_next;

  assign sample.ready = !ch_valid || ch_ready;

  always_comb begin
    p0 = PROD_W'(sample.broadband_count) * PROD_W'(CHAN_FACTOR);
    p1 = PROD_W'(sample.infrared_count) * PROD_W'(CHAN_FACTOR);
    ch_next.c0 = p0[PROD_W-1:CHAN_SHIFT];
    ch_next.c1 = p1[PROD_W-1:CHAN_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid <= 1'b0;
    end else if (sample.ready) begin
      ch_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      ch <= ch_next;
    end
  end
endmodule
`default_nettype wire

@@ sv/llfc_knee.sv @@
`default_nettype none
module llfc_knee (
  input  logic              clk,
  input  logic              rst,
  input  logic              ch_valid,
  output logic              ch_ready,
  input  llfc_pkg::scaled_t ch,
  output logic              knee_valid,
  input  logic              knee_ready,
  output llfc_pkg::knee_t   knee
);
  import llfc_pkg::*;

  // round(q/2) <= k  <=>  c1 << (RATIO_BITS+1) < (2k+1) * c0, no divide needed
  logic [CMP_W-1:0]     num;
  logic [SEG_COUNT-1:0] hit_next;

  assign ch_ready = !knee_valid || knee_ready;

  always_comb begin
    num = CMP_W'({ch.c1, {(RATIO_BITS + 1){1'b0}}});
    for (int i = 0; i < SEG_COUNT; i++) begin
      // zero broadband means ratio 0: every knee passes
      hit_next[i] = (ch.c0 == '0) ||
                    (num < CMP_W'(ch.c0) * CMP_W'({KNEE[i], 1'b1}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      knee_valid <= 1'b0;
    end else if (ch_ready) begin
      knee_valid <= ch_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ch_ready && ch_valid) begin
      knee.ch  <= ch;
      knee.hit <= hit_next;
    end
  end
endmodule
`default_nettype wire

@@ sv/llfc_coef.sv @@
`default_nettype none
module llfc_coef (
  input  logic             clk,
  input  logic             rst,
  input  logic             knee_valid,
  output logic             knee_ready,
  input  llfc_pkg::knee_t  knee,
  output logic             terms_valid,
  input  logic             terms_ready,
  output llfc_pkg::terms_t terms
);
  import llfc_pkg::*;

  logic [COEF_W-1:0] b;
  logic [COEF_W-1:0] m;
  terms_t            terms_next;

  assign knee_ready = !terms_valid || terms_ready;

  // first passing knee wins; none passing (ratio past 1.3) gives zero
  always_comb begin
    b = '0;
    m = '0;
    for (int i = SEG_COUNT - 1; i >= 0; i--) begin
      if (knee.hit[i]) begin
        b = ICEPT[i];
        m = SLOPE[i];
      end
    end
    terms_next.pos = PROD_W'(knee.ch.c0) * PROD_W'(b);
    terms_next.neg = PROD_W'(knee.ch.c1) * PROD_W'(m);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      terms_valid <= 1'b0;
    end else if (knee_ready) begin
      terms_valid <= knee_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (knee_ready && knee_valid) begin
      terms <= terms_next;
    end
  end
endmodule
`default_nettype wire

@@ sv/llfc_round.sv @@
`default_nettype none
module llfc_round (
  input  logic             clk,
  input  logic             rst,
  input  logic             terms_valid,
  output logic             terms_ready,
  input  llfc_pkg::terms_t terms,
  llfc_out_if.source       result
);
  import llfc_pkg::*;

  logic [PROD_W-1:0] diff;
  logic [PROD_W:0]   rounded;
  logic [LUX_W-1:0]  lux_next;

  assign terms_ready = !result.valid || result.ready;

  always_comb begin
    diff     = (terms.pos >= terms.neg) ? (terms.pos - terms.neg) : '0;
    rounded  = {1'b0, diff} + ((PROD_W + 1)'(1) << (LUX_BITS - 1));
    // shifted value is 22 bits wide, so it never reaches the 24-bit clamp
    lux_next = LUX_W'(rounded[PROD_W:LUX_BITS]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (terms_ready) begin
      result.valid <= terms_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (terms_ready && terms_valid) begin
      result.lux <= lux_next;
    end
  end
endmodule
`default_nettype wire

@@ sv/light_lux_from_channels_top.sv @@
// Lux from a broadband/infrared count pair. One pair is taken every clock while
// the result is not back-pressured, and each lux value passes through four
// register stages: channel scaling multipliers, breakpoint compares on the
// infrared/broadband ratio, intercept and slope multipliers, and the final
// subtract, round and shift. Each stage holds its item while the next one is
// full, so back-pressure on the result stalls the pipe without loss; the input
// stays ready as long as some stage has room.
`default_nettype none
`include "light_lux_from_channels_top_macros.svh"
module light_lux_from_channels_top (
  input  logic       clk,
  input  logic       rst,
  llfc_in_if.sink    sample,
  llfc_out_if.source result
);
  import llfc_pkg::*;

  logic    ch_valid;
  logic    ch_ready;
  scaled_t ch;
  logic    knee_valid;
  logic    knee_ready;
  knee_t   knee;
  logic    terms_valid;
  logic    terms_ready;
  terms_t  terms;

  // set where a knee passes but the next one up does not
  logic [SEG_COUNT-2:0] hit_gap;

  llfc_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .ch_valid (ch_valid),
    .ch_ready (ch_ready),
    .ch       (ch)
  );

  llfc_knee u_knee (
    .clk        (clk),
    .rst        (rst),
    .ch_valid   (ch_valid),
    .ch_ready   (ch_ready),
    .ch         (ch),
    .knee_valid (knee_valid),
    .knee_ready (knee_ready),
    .knee       (knee)
  );

  llfc_coef u_coef (
    .clk         (clk),
    .rst         (rst),
    .knee_valid  (knee_valid),
    .knee_ready  (knee_ready),
    .knee        (knee),
    .terms_valid (terms_valid),
    .terms_ready (terms_ready),
    .terms       (terms)
  );

  llfc_round u_round (
    .clk         (clk),
    .rst         (rst),
    .terms_valid (terms_valid),
    .terms_ready (terms_ready),
    .terms       (terms),
    .result      (result)
  );

  assign hit_gap = knee.hit[SEG_COUNT-2:0] & ~knee.hit[SEG_COUNT-1:1];

  // an accepted request always lands in the first stage
  `LLFC_ASSERT_NEXT(a_accept_fills, clk, rst, sample.valid && sample.ready, ch_valid)
  // an empty first stage never refuses a request
  `LLFC_ASSERT_NOW(a_ready_when_empty, clk, rst, !ch_valid, sample.ready)
  // knees increase, so passing flags form one run up to the last segment
  `LLFC_ASSERT_NOW(a_knee_monotone, clk, rst, knee_valid, hit_gap == '0)
  // zero broadband selects the first segment
  `LLFC_ASSERT_NOW(a_zero_broadband, clk, rst, knee_valid && (knee.ch.c0 == '0), knee.hit[0])
endmodule
`default_nettype wire

@@ tb/sv/light_lux_from_channels_top_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module light_lux_from_channels_top_tb;
  import llfc_pkg::*;

  logic clk;
  logic rst;

  llfc_in_if  sample_if ();
  llfc_out_if result_if ();

  light_lux_from_channels_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if.sink),
    .result (result_if.source)
  );

  logic [LUX_W-1:0] lux_expected [$];
  int unsigned      errors;
  bit               in_gaps_on;
  bit               out_stalls_on;

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Lux from one raw pair, carried at 64 bits so no product wraps.
  function automatic logic [LUX_W-1:0] predict_lux(input logic [RAW_W-1:0] bb,
                                                   input logic [RAW_W-1:0] ir);
    logic [63:0] c0;
    logic [63:0] c1;
    logic [63:0] ratio;
    logic [63:0] b;
    logic [63:0] m;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] diff;
    logic [63:0] lux_full;
    bit          found;
    c0 = (64'(bb) * 64'(CHAN_FACTOR)) >> CHAN_SHIFT;
    c1 = (64'(ir) * 64'(CHAN_FACTOR)) >> CHAN_SHIFT;
    ratio = 64'd0;
    if (c0 != 64'd0) begin
      ratio = ((c1 << (RATIO_BITS + 1)) / c0 + 64'd1) >> 1;
    end
    b = 64'd0;
    m = 64'd0;
    found = 1'b0;
    for (int i = 0; i < SEG_COUNT; i++) begin
      if (!found && ratio <= 64'(KNEE[i])) begin
        b = 64'(ICEPT[i]);
        m = 64'(SLOPE[i]);
        found = 1'b1;
      end
    end
    pos = c0 * b;
    neg = c1 * m;
    diff = (pos >= neg) ? (pos - neg) : 64'd0;
    lux_full = (diff + (64'd1 << (LUX_BITS - 1))) >> LUX_BITS;
    if (lux_full > 64'hFF_FFFF) begin
      lux_full = 64'hFF_FFFF;
    end
    return lux_full[LUX_W-1:0];
  endfunction

  // Push on every accepted request, then match every accepted result.
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_if.valid && sample_if.ready) begin
        lux_expected.push_back(predict_lux(sample_if.broadband_count,
                                           sample_if.infrared_count));
      end
      if (result_if.valid && result_if.ready) begin
        if (lux_expected.size() == 0) begin
          $display("%0t unexpected lux: expected none actual %0d", $time, result_if.lux);
          errors++;
        end else begin
          if (result_if.lux !== lux_expected[0]) begin
            $display("%0t lux mismatch: expected %0d actual %0d",
                     $time, lux_expected[0], result_if.lux);
            errors++;
          end
          void'(lux_expected.pop_front());
        end
      end
    end
  end

  // Result side back-pressure in bursts.
  initial begin
    result_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_stalls_on && $urandom_range(0, 3) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        result_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_pair(input logic [RAW_W-1:0] bb, input logic [RAW_W-1:0] ir);
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      sample_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    sample_if.valid           <= 1'b1;
    sample_if.broadband_count <= bb;
    sample_if.infrared_count  <= ir;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
  endtask

  // Infrared count that lands the ratio close to a chosen breakpoint.
  function automatic logic [RAW_W-1:0] ir_near_knee(input logic [RAW_W-1:0] bb,
                                                    input int seg, input int offs);
    longint target;
    longint ir_val;
    target = longint'(KNEE[seg]) + offs;
    if (target < 0) begin
      target = 0;
    end
    ir_val = (longint'(bb) * target + 256) / 512;
    if (ir_val > 65535) begin
      ir_val = 65535;
    end
    return RAW_W'(ir_val);
  endfunction

  task automatic run_directed();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    send_pair(16'h0000, 16'h0000);
    send_pair(16'h0000, 16'hFFFF);  // zero broadband, ratio forced to 0
    send_pair(16'hFFFF, 16'h0000);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'h0001, 16'h0001);
    send_pair(16'd1000, 16'd1400);  // ratio past the last knee
    for (int k = 0; k < SEG_COUNT; k++) begin
      send_pair(16'd1024, RAW_W'(2 * KNEE[k]));
      send_pair(16'd1024, RAW_W'(2 * KNEE[k] + 1));
    end
  endtask

  task automatic run_random_mix(input int count);
    logic [RAW_W-1:0] bb;
    logic [RAW_W-1:0] ir;
    int               pick;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 19);
      bb = RAW_W'($urandom);
      ir = RAW_W'($urandom);
      if (pick < 3) begin
        bb = RAW_W'($urandom_range(0, 15));
        ir = RAW_W'($urandom_range(0, 15));
      end else if (pick < 6 && ir < bb) begin
        ir = ~ir;
        bb = ~bb;
      end
      send_pair(bb, ir);
    end
  endtask

  task automatic run_knee_sweep(input int count);
    logic [RAW_W-1:0] bb;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    for (int n = 0; n < count; n++) begin
      bb = ($urandom_range(0, 3) == 0) ? RAW_W'($urandom_range(1, 255)) : RAW_W'($urandom);
      send_pair(bb, ir_near_knee(bb, $urandom_range(0, SEG_COUNT - 1),
                                 $urandom_range(0, 4) - 2));
    end
  endtask

  task automatic run_streaming(input int count);
    logic [RAW_W-1:0] bb;
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    for (int n = 0; n < count; n++) begin
      bb = RAW_W'($urandom);
      if (n % 2 == 0) begin
        send_pair(bb, RAW_W'($urandom));
      end else begin
        send_pair(bb, ir_near_knee(bb, $urandom_range(0, SEG_COUNT - 1),
                                   $urandom_range(0, 4) - 2));
      end
    end
  endtask

  initial begin
    errors = 0;
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    rst <= 1'b1;
    sample_if.valid           <= 1'b0;
    sample_if.broadband_count <= '0;
    sample_if.infrared_count  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_random_mix(600);
    run_knee_sweep(400);
    run_streaming(200);

    sample_if.valid <= 1'b0;
    while (lux_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
